/* rtl/core/max_heap_priority_queue_macros.svh */
// Assertion macros used by the heap queue RTL.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mhpq_pkg.sv */
// Constants and codes for the max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = ADDR_W + 2;   // holds 2*i+2 for any slot i
  localparam int VALUE_W    = 32;
  localparam int OUT_CNT_W  = 11;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/mhpq_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* rtl/core/max_heap_priority_queue.sv */
// Binary max-heap priority queue: push a signed value or pop the maximum, one result each.
// Each transfer in is a push (tuser 0) or a pop (tuser 1) and yields exactly one
// transfer out with the current maximum, the entry count and a status. The heap
// lives in one 1024 x 32 RAM with a registered read; the root is also
// kept in a register. A push writes a hole at the end and walks it up one level
// per cycle (one parent read per level); a pop reads the last entry, then walks
// down one level per cycle, reading both children through the two read ports.
// A full push, an empty pop, a push into an empty heap and a pop of the last
// entry go straight to the result; any other item takes as long as the
// one-level-per-cycle RAM walk needs, plus any time the finished result
// waits for the output register to drain. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "max_heap_priority_queue_macros.svh"
module max_heap_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [0:0]  in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // [31:0] top_value, [42:32] entry_count, rest zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = mhpq_pkg::ADDR_W;
  localparam int DW = mhpq_pkg::DATA_WIDTH;
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int IW = mhpq_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LOAD,
    S_DOWN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [DW-1:0]       val_r, val_nxt;
  logic [AW-1:0]       hole_r, hole_nxt;
  logic [DW-1:0]       top_r, top_nxt;
  logic [DW-1:0]       root_r, root_nxt;
  mhpq_pkg::status_t   status_r, status_nxt;
  logic                pop_r, pop_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [mhpq_pkg::VALUE_W-1:0]   out_top_r, out_top_nxt;
  logic [mhpq_pkg::OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  mhpq_pkg::status_t   out_status_r, out_status_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_ra, mem_rb;
  logic [DW-1:0]       mem_wdata, mem_rd_a, mem_rd_b;

  logic [DW-1:0]       in_val;
  logic                in_xfer;
  logic [AW-1:0]       in_parent, up_idx, up2_idx;
  logic [IW-1:0]       cnt_x, lc_h, rc_h, best_idx, blc;
  logic                go_left, go_right;
  logic [DW-1:0]       bv_left, best_val;

  mhpq_ram #(
    .WIDTH (DW),
    .DEPTH (mhpq_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_ra),
    .raddr_b (mem_rb),
    .rdata_a (mem_rd_a),
    .rdata_b (mem_rd_b)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_val    = DW'(signed'(in_tdata));

  // Tree index arithmetic: parent = (i-1)/2, children = 2i+1, 2i+2.
  assign in_parent = AW'((count_r - 1'b1) >> 1);
  assign up_idx    = AW'((hole_r - 1'b1) >> 1);
  assign up2_idx   = AW'((up_idx - 1'b1) >> 1);
  assign cnt_x     = IW'(count_r);
  assign lc_h      = IW'({hole_r, 1'b1});
  assign rc_h      = lc_h + 1'b1;

  // Sift-down choice; the left child wins a tie.
  assign go_left  = $signed(val_r) < $signed(mem_rd_a);
  assign bv_left  = go_left ? mem_rd_a : val_r;
  assign go_right = (rc_h < cnt_x) && ($signed(bv_left) < $signed(mem_rd_b));
  assign best_val = go_right ? mem_rd_b : bv_left;
  assign best_idx = go_right ? rc_h : lc_h;
  assign blc      = IW'({best_idx[AW-1:0], 1'b1});

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    val_nxt        = val_r;
    hole_nxt       = hole_r;
    top_nxt        = top_r;
    root_nxt       = root_r;
    status_nxt     = status_r;
    pop_nxt        = pop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_top_nxt    = out_top_r;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = hole_r;
    mem_wdata      = val_r;
    mem_ra         = up2_idx;
    mem_rb         = rc_h[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          pop_nxt    = (in_tuser == mhpq_pkg::FUNC_POP);
          status_nxt = mhpq_pkg::ST_OK;
          if (in_tuser == mhpq_pkg::FUNC_PUSH) begin
            if (count_r >= CW'(mhpq_pkg::CAPACITY)) begin
              status_nxt = mhpq_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r + 1'b1;
              val_nxt   = in_val;
              if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_val;
                state_nxt = S_DONE;
              end else begin
                hole_nxt  = count_r[AW-1:0];
                mem_ra    = in_parent;
                state_nxt = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = mhpq_pkg::ST_EMPTY;
              top_nxt    = '0;
              state_nxt  = S_DONE;
            end else begin
              top_nxt   = root_r;
              count_nxt = count_r - 1'b1;
              hole_nxt  = '0;
              if (count_r == CW'(1)) begin
                state_nxt = S_DONE;
              end else begin
                // fetch the last entry, it becomes the new root
                mem_ra    = AW'(count_r - 1'b1);
                state_nxt = S_LOAD;
              end
            end
          end
        end
      end
      S_UP: begin
        if ($signed(mem_rd_a) < $signed(val_r)) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rd_a;
          hole_nxt  = up_idx;
          if (up_idx == '0) begin
            state_nxt = S_PLACE;
          end else begin
            mem_ra = up2_idx;
          end
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        val_nxt = mem_rd_a;
        if (lc_h < cnt_x) begin
          mem_ra    = lc_h[AW-1:0];
          mem_rb    = rc_h[AW-1:0];
          state_nxt = S_DOWN;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rd_a;
          state_nxt = S_DONE;
        end
      end
      S_DOWN: begin
        mem_we = 1'b1;
        if (!go_left && !go_right) begin
          state_nxt = S_DONE;
        end else begin
          mem_wdata = best_val;
          hole_nxt  = best_idx[AW-1:0];
          if (blc < cnt_x) begin
            mem_ra = blc[AW-1:0];
            mem_rb = AW'(blc + 1'b1);
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = mhpq_pkg::VALUE_W'(signed'(pop_r ? top_r : root_r));
          out_cnt_nxt    = mhpq_pkg::OUT_CNT_W'(count_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // root shadow follows every write to slot zero
    if (mem_we && (mem_waddr == '0)) begin
      root_nxt = mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r        <= val_nxt;
    hole_r       <= hole_nxt;
    top_r        <= top_nxt;
    root_r       <= root_nxt;
    status_r     <= status_nxt;
    pop_r        <= pop_nxt;
    out_top_r    <= out_top_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_top_r};
  assign out_tuser  = out_status_r;

  `MHPQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(mhpq_pkg::CAPACITY), "fill count beyond capacity")
  `MHPQ_ASSERT_NEXT(a_empty_pop, in_xfer && (in_tuser == mhpq_pkg::FUNC_POP) && (count_r == '0), (state_r == S_DONE) && (status_r == mhpq_pkg::ST_EMPTY), "empty pop not flagged")
  `MHPQ_ASSERT_NEXT(a_push_count, in_xfer && (in_tuser == mhpq_pkg::FUNC_PUSH) && (count_r < CW'(mhpq_pkg::CAPACITY)), count_r == CW'($past(count_r) + 1'b1), "push did not grow the heap")
  `MHPQ_ASSERT_NOW(a_down_child, state_r == S_DOWN, lc_h < cnt_x, "sift-down on a slot without children")
  `MHPQ_ASSERT_NOW(a_full_count, out_valid_r && (out_status_r == mhpq_pkg::ST_FULL), out_cnt_r == mhpq_pkg::OUT_CNT_W'(mhpq_pkg::CAPACITY), "full status with heap not full")

endmodule
`default_nettype wire
